@@ hw/rtl/apu_nonlinear_mixer_filter_macros.svh @@
// assertion macros for the apu nonlinear mixer filter
// expects clk and rst_n in the scope of use
`ifndef APU_NONLINEAR_MIXER_FILTER_MACROS_SVH
`define APU_NONLINEAR_MIXER_FILTER_MACROS_SVH

// same-cycle implication
`define ANMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anmf assertion failed");

// next-cycle implication
`define ANMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anmf assertion failed");

`endif

@@ hw/rtl/anmf_pkg.sv @@
// shared types, constants and helpers of the apu nonlinear mixer filter
// used by anmf_ctrl, anmf_dp and the top level
`timescale 1ns / 1ps

package anmf_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 16;
    localparam int ST_W      = 18;
    localparam int QW        = 17;
    localparam int DIV_W     = 64;
    localparam int CNT_W     = $clog2(QW);
    localparam int NSUM_W    = 35;

    localparam logic [CFG_W-1:0] HP_COEFF_RESET = 16'd65274;
    localparam logic [CFG_W-1:0] LP_COEFF_RESET = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS  = 8'd1;

    // resistor ladder weights
    localparam logic [NSUM_W-1:0] K_TRI   = 35'd277111758;
    localparam logic [NSUM_W-1:0] K_NOISE = 35'd186242826;
    localparam logic [NSUM_W-1:0] K_DELTA = 35'd100706707;
    localparam logic [DIV_W-1:0]  K_PROD  = 64'd2279798433066;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NSUM,
        ST_DIV_P,
        ST_PREP_T,
        ST_DIV_T,
        ST_RAW,
        ST_HP_MUL,
        ST_HP_FIN,
        ST_LP_MUL,
        ST_LP_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_NSUM,
        OP_DIV,
        OP_PREP_T,
        OP_RAW,
        OP_HP_MUL,
        OP_HP_FIN,
        OP_LP_MUL,
        OP_LP_FIN,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_stat_t;

    // saturate to the 18 bit state range
    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [21:0] v);
        logic signed [ST_W-1:0] r;
        if (v > 22'sd131071)
            r = 18'sd131071;
        else if (v < -22'sd131072)
            r = -18'sd131072;
        else
            r = v[ST_W-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/anmf_ctrl.sv @@
// sequencer of the apu nonlinear mixer filter
// depends on anmf_pkg
`timescale 1ns / 1ps

module anmf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  anmf_pkg::dp_stat_t stat,
    output anmf_pkg::dp_cmd_t  cmd
);

    anmf_pkg::state_t state_reg;
    anmf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= anmf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            anmf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = anmf_pkg::ST_NSUM;
            end
            anmf_pkg::ST_NSUM:   state_next = anmf_pkg::ST_DIV_P;
            anmf_pkg::ST_DIV_P:
            begin
                if (stat.div_last)
                    state_next = anmf_pkg::ST_PREP_T;
            end
            anmf_pkg::ST_PREP_T: state_next = anmf_pkg::ST_DIV_T;
            anmf_pkg::ST_DIV_T:
            begin
                if (stat.div_last)
                    state_next = anmf_pkg::ST_RAW;
            end
            anmf_pkg::ST_RAW:    state_next = anmf_pkg::ST_HP_MUL;
            anmf_pkg::ST_HP_MUL: state_next = anmf_pkg::ST_HP_FIN;
            anmf_pkg::ST_HP_FIN: state_next = anmf_pkg::ST_LP_MUL;
            anmf_pkg::ST_LP_MUL: state_next = anmf_pkg::ST_LP_FIN;
            anmf_pkg::ST_LP_FIN: state_next = anmf_pkg::ST_OUT;
            anmf_pkg::ST_OUT:
            begin
                if (stat.out_free)
                    state_next = anmf_pkg::ST_IDLE;
            end
            default:             state_next = anmf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = anmf_pkg::OP_IDLE;
        in_ready = 1'b0;
        unique case (state_reg)
            anmf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = anmf_pkg::OP_LOAD;
            end
            anmf_pkg::ST_NSUM:   cmd.op = anmf_pkg::OP_NSUM;
            anmf_pkg::ST_DIV_P:  cmd.op = anmf_pkg::OP_DIV;
            anmf_pkg::ST_PREP_T: cmd.op = anmf_pkg::OP_PREP_T;
            anmf_pkg::ST_DIV_T:  cmd.op = anmf_pkg::OP_DIV;
            anmf_pkg::ST_RAW:    cmd.op = anmf_pkg::OP_RAW;
            anmf_pkg::ST_HP_MUL: cmd.op = anmf_pkg::OP_HP_MUL;
            anmf_pkg::ST_HP_FIN: cmd.op = anmf_pkg::OP_HP_FIN;
            anmf_pkg::ST_LP_MUL: cmd.op = anmf_pkg::OP_LP_MUL;
            anmf_pkg::ST_LP_FIN: cmd.op = anmf_pkg::OP_LP_FIN;
            anmf_pkg::ST_OUT:
            begin
                if (stat.out_free)
                    cmd.op = anmf_pkg::OP_OUT;
            end
            default:             cmd.op = anmf_pkg::OP_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/anmf_dp.sv @@
// datapath of the apu nonlinear mixer filter: mix terms, shared divider, filters
// depends on anmf_pkg
`timescale 1ns / 1ps

module anmf_dp
#(
    parameter int OUT_FRAC_BITS = anmf_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  anmf_pkg::dp_cmd_t             cmd,
    output anmf_pkg::dp_stat_t            stat,
    input  logic [3:0]                    pulse_a_level,
    input  logic [3:0]                    pulse_b_level,
    input  logic [3:0]                    tri_level,
    input  logic [3:0]                    noise_level,
    input  logic [6:0]                    delta_level,
    input  logic [anmf_pkg::CFG_W-1:0]    highpass_coeff,
    input  logic [anmf_pkg::CFG_W-1:0]    lowpass_coeff,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [anmf_pkg::OUT_W-1:0] audio_sample
);

    localparam int DW  = anmf_pkg::DIV_W;
    localparam int SW  = anmf_pkg::ST_W;
    localparam int QW  = anmf_pkg::QW;
    localparam int SHR = (OUT_FRAC_BITS <= 16) ? 16 - OUT_FRAC_BITS : 0;
    localparam int SHL = (OUT_FRAC_BITS > 16) ? OUT_FRAC_BITS - 16 : 0;
    localparam logic signed [23:0] ORND = (SHR > 0) ? (24'sd1 <<< ((SHR > 0) ? SHR - 1 : 0))
                                                    : 24'sd0;

    logic [4:0]                      s_reg, s_next;
    logic [3:0]                      t_reg, t_next;
    logic [3:0]                      n_reg, n_next;
    logic [6:0]                      d_reg, d_next;
    logic [anmf_pkg::NSUM_W-1:0]     nsum_reg, nsum_next;
    logic [DW-1:0]                   rem_reg, rem_next;
    logic [DW-1:0]                   dsh_reg, dsh_next;
    logic [QW-1:0]                   q_reg, q_next;
    logic [anmf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [QW-1:0]                   pq_reg, pq_next;
    logic signed [SW-1:0]            raw_reg, raw_next;
    logic signed [19:0]              diff_reg, diff_next;
    logic signed [36:0]              prod_reg, prod_next;
    logic signed [SW-1:0]            hp_li_reg, hp_li_next;
    logic signed [SW-1:0]            hp_lo_reg, hp_lo_next;
    logic signed [SW-1:0]            lp_lo_reg, lp_lo_next;
    logic                            ov_reg, ov_next;
    logic signed [anmf_pkg::OUT_W-1:0] od_reg, od_next;

    logic [DW-1:0]          num_v, den_v;
    logic [18:0]            p_mul;
    logic [20:0]            p_den;
    logic [48:0]            t_mul;
    logic [QW:0]            raw_sum;
    logic signed [36:0]     rnd_prod;
    logic signed [20:0]     rnd_sh;
    logic signed [18:0]     lp_diff;
    logic signed [23:0]     o_wide;
    logic signed [23:0]     o_conv;

    always_comb
    begin
        s_next     = s_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        nsum_next  = nsum_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        pq_next    = pq_reg;
        raw_next   = raw_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        hp_li_next = hp_li_reg;
        hp_lo_next = hp_lo_reg;
        lp_lo_next = lp_lo_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;

        p_mul    = 19'(s_reg) * 19'd9588;
        p_den    = 21'd812800 + 21'(s_reg) * 21'd10000;
        t_mul    = 49'(nsum_reg) * 49'd15979;
        num_v    = '0;
        den_v    = '0;
        raw_sum  = 18'(pq_reg) + 18'(q_reg);
        rnd_prod = prod_reg + 37'sd32768;
        rnd_sh   = rnd_prod[36:16];
        lp_diff  = 19'(hp_lo_reg) - 19'(lp_lo_reg);
        o_wide   = 24'(lp_lo_reg);
        o_conv   = ((o_wide + ORND) >>> SHR) <<< SHL;

        unique case (cmd.op)
            anmf_pkg::OP_LOAD:
            begin
                s_next = 5'(pulse_a_level) + 5'(pulse_b_level);
                t_next = tri_level;
                n_next = noise_level;
                d_next = delta_level;
            end
            anmf_pkg::OP_NSUM:
            begin
                nsum_next = 35'(t_reg) * anmf_pkg::K_TRI
                          + 35'(n_reg) * anmf_pkg::K_NOISE
                          + 35'(d_reg) * anmf_pkg::K_DELTA;
                // pulse group fraction into the divider
                num_v    = 64'(p_mul) << 16;
                den_v    = 64'(p_den);
                rem_next = num_v + (den_v >> 1);
                dsh_next = den_v << (QW - 1);
                q_next   = '0;
                cnt_next = anmf_pkg::CNT_W'(QW - 1);
            end
            anmf_pkg::OP_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[QW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
            anmf_pkg::OP_PREP_T:
            begin
                pq_next  = q_reg;
                num_v    = 64'(t_mul) << 14;
                den_v    = (anmf_pkg::K_PROD + 64'(nsum_reg) * 64'd100) * 64'd25;
                rem_next = num_v + (den_v >> 1);
                dsh_next = den_v << (QW - 1);
                q_next   = '0;
                cnt_next = anmf_pkg::CNT_W'(QW - 1);
            end
            anmf_pkg::OP_RAW:
            begin
                raw_next  = SW'(raw_sum);
                diff_next = 20'(hp_lo_reg) + 20'(signed'(raw_sum)) - 20'(hp_li_reg);
            end
            anmf_pkg::OP_HP_MUL:
            begin
                prod_next = 37'(signed'({1'b0, highpass_coeff})) * 37'(diff_reg);
            end
            anmf_pkg::OP_HP_FIN:
            begin
                hp_lo_next = anmf_pkg::sat_st(22'(rnd_sh));
                hp_li_next = raw_reg;
            end
            anmf_pkg::OP_LP_MUL:
            begin
                prod_next = 37'(signed'({1'b0, lowpass_coeff})) * 37'(lp_diff);
            end
            anmf_pkg::OP_LP_FIN:
            begin
                lp_lo_next = anmf_pkg::sat_st(22'(rnd_sh) + 22'(lp_lo_reg));
            end
            anmf_pkg::OP_OUT:
            begin
                ov_next = 1'b1;
                if (o_conv > 24'sd32767)
                    od_next = 16'sh7fff;
                else if (o_conv < -24'sd32768)
                    od_next = -16'sd32768;
                else
                    od_next = o_conv[15:0];
            end
            default:
            begin
            end
        endcase
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        nsum_reg <= nsum_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        pq_reg   <= pq_next;
        raw_reg  <= raw_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        od_reg   <= od_next;
    end

    // filter history, divider count and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            hp_li_reg <= '0;
            hp_lo_reg <= '0;
            lp_lo_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            hp_li_reg <= hp_li_next;
            hp_lo_reg <= hp_lo_next;
            lp_lo_reg <= lp_lo_next;
            ov_reg    <= ov_next;
        end
    end

    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_free = !ov_reg || out_ready;
    assign out_valid     = ov_reg;
    assign audio_sample  = od_reg;

endmodule

@@ hw/rtl/apu_nonlinear_mixer_filter.sv @@
// top level of the apu nonlinear mixer filter: stream ports, coefficient registers
// depends on anmf_pkg, anmf_ctrl, anmf_dp and apu_nonlinear_mixer_filter_macros.svh
`timescale 1ns / 1ps

// one beat in gives one audio sample out. a beat is taken only while the block is
// idle; from acceptance to the result register it runs through the channel weight
// sum, two passes of the shared restoring divider (pulse group, then
// triangle/noise/delta group) with a step between them to set up the second
// division, the raw mix, the high-pass and low-pass multiply and round steps, and a
// rescale into the output register. the block then goes back to idle to accept the
// next beat, so a new beat is not taken before the last one is in the result register.
// the result register holds a finished sample while the next one is worked on; if it
// is still full at the end, the sequencer waits. coefficients are written through the
// cfg channel, index 0 for the high-pass coefficient and 1 for the low-pass one, other
// indexes are dropped.
module apu_nonlinear_mixer_filter
#(
    parameter int OUT_FRAC_BITS = anmf_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pulse_a_level[3:0], pulse_b_level[7:4], tri_level[11:8], noise_level[15:12],
    // delta_level[22:16], zero pad [23]
    input  logic [anmf_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // audio_sample[15:0]
    output logic [anmf_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [anmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [anmf_pkg::CFG_W-1:0]        cfg_data
);

    logic [anmf_pkg::CFG_W-1:0] hp_coeff_reg, hp_coeff_next;
    logic [anmf_pkg::CFG_W-1:0] lp_coeff_reg, lp_coeff_next;

    anmf_pkg::dp_cmd_t  cmd;
    anmf_pkg::dp_stat_t stat;
    logic signed [anmf_pkg::OUT_W-1:0] audio_sample;

    // coefficients are always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        hp_coeff_next = hp_coeff_reg;
        lp_coeff_next = lp_coeff_reg;
        if (cfg_valid)
        begin
            priority if (cfg_index == anmf_pkg::REG_HIGHPASS)
                hp_coeff_next = cfg_data;
            else if (cfg_index == anmf_pkg::REG_LOWPASS)
                lp_coeff_next = cfg_data;
            else
            begin
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_coeff_reg <= anmf_pkg::HP_COEFF_RESET;
            lp_coeff_reg <= anmf_pkg::LP_COEFF_RESET;
        end
        else
        begin
            hp_coeff_reg <= hp_coeff_next;
            lp_coeff_reg <= lp_coeff_next;
        end
    end

    anmf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    anmf_dp
    #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .pulse_a_level  (s_tdata[3:0]),
        .pulse_b_level  (s_tdata[7:4]),
        .tri_level      (s_tdata[11:8]),
        .noise_level    (s_tdata[15:12]),
        .delta_level    (s_tdata[22:16]),
        .highpass_coeff (hp_coeff_reg),
        .lowpass_coeff  (lp_coeff_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .audio_sample   (audio_sample)
    );

    assign m_tdata = audio_sample;

    // checks on the sequencing
`include "apu_nonlinear_mixer_filter_macros.svh"

    // one beat at a time: no second beat right after an accepted one
    `ANMF_ASSERT_NXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready)
    // a result is loaded only into a free output slot
    `ANMF_ASSERT_IMP(a_out_slot_free, cmd.op == anmf_pkg::OP_OUT, !m_tvalid || m_tready)
    // a load command comes only with an accepted beat
    `ANMF_ASSERT_IMP(a_load_on_beat, cmd.op == anmf_pkg::OP_LOAD, s_tvalid && s_tready)

endmodule

@@ verif/tb_apu_nonlinear_mixer_filter.sv @@
// testbench for apu_nonlinear_mixer_filter: directed and random channel levels
// under reset, fixed and random coefficient settings, checked against an in-bench fixed point mixer
// depends on anmf_pkg and the apu_nonlinear_mixer_filter rtl
`timescale 1ns / 1ps

module tb_apu_nonlinear_mixer_filter;

    localparam int OUT_FRAC   = 14;
    localparam int SETTLE     = 60;       // idle cycles in drain after the last sample is back
    localparam int CYCLE_CAP  = 800000;
    localparam int RAND_ITEMS = 120;      // per random phase, four phases

    localparam longint Q_MAX = 131071;
    localparam longint Q_MIN = -131072;
    // resistor ladder products for the triangle/noise/delta group
    localparam longint W_TRI   = 64'd12241 * 64'd22638;
    localparam longint W_NOISE = 64'd8227 * 64'd22638;
    localparam longint W_DELTA = 64'd8227 * 64'd12241;
    localparam longint P_ALL   = 64'd8227 * 64'd12241 * 64'd22638;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [anmf_pkg::IN_W-1:0]      s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [anmf_pkg::OUT_W-1:0]     m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [anmf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [anmf_pkg::CFG_W-1:0]     cfg_data;

    // predictor copy of the coefficients and filter history
    logic [anmf_pkg::CFG_W-1:0] hp_coeff;
    logic [anmf_pkg::CFG_W-1:0] lp_coeff;
    longint                     hp_mem_in;
    longint                     hp_mem_out;
    longint                     lp_mem_out;

    logic [anmf_pkg::OUT_W-1:0] samples_due[$];
    int               mismatches;
    int               cycles;
    bit               calm;         // no gaps and no stalls while set
    int               stall_left;

    apu_nonlinear_mixer_filter #(.OUT_FRAC_BITS(OUT_FRAC)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // arithmetic shift with round to nearest, ties toward plus infinity
    function automatic longint shift_round(input longint v, input int sh);
        if (sh == 0)
            return v;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // mixes one set of levels, runs both filters and advances their history
    function automatic logic [anmf_pkg::OUT_W-1:0] mix_and_filter(input logic [3:0] pa,
        input logic [3:0] pb, input logic [3:0] tr, input logic [3:0] nz,
        input logic [6:0] dl);
        longint unsigned s;
        longint unsigned n;
        longint unsigned num;
        longint unsigned den;
        longint pulse_q;
        longint tnd_q;
        longint raw;
        longint hp;
        longint lp;
        longint o;
        s       = pa + pb;
        pulse_q = 0;
        tnd_q   = 0;
        // silent group contributes nothing
        if (s != 0)
        begin
            num     = 64'd9588 * s * 64'd65536;
            den     = 64'd812800 + 64'd10000 * s;
            pulse_q = (num + den / 2) / den;
        end
        n = tr * W_TRI + nz * W_NOISE + dl * W_DELTA;
        if (n != 0)
        begin
            num   = 64'd15979 * n * 64'd16384;
            den   = 64'd25 * (P_ALL + 64'd100 * n);
            tnd_q = (num + den / 2) / den;
        end
        raw = pulse_q + tnd_q;
        hp  = shift_round(longint'(hp_coeff) * (hp_mem_out + raw - hp_mem_in), 16);
        hp  = sat(hp, Q_MIN, Q_MAX);
        hp_mem_in  = raw;
        hp_mem_out = hp;
        lp  = lp_mem_out + shift_round(longint'(lp_coeff) * (hp - lp_mem_out), 16);
        lp  = sat(lp, Q_MIN, Q_MAX);
        lp_mem_out = lp;
        if (OUT_FRAC <= 16)
            o = shift_round(lp, 16 - OUT_FRAC);
        else
            o = lp * (longint'(1) << (OUT_FRAC - 16));
        o = sat(o, -32768, 32767);
        return o[anmf_pkg::OUT_W-1:0];
    endfunction

    // ---------------------------------------------------------------- idling

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    // result side back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (samples_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample beat: audio_sample %0d",
                             $signed(m_tdata));
            end
            else
            begin
                if (m_tdata !== samples_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("audio_sample mismatch: expected %0d, got %0d",
                                 $signed(samples_due[0]), $signed(m_tdata));
                end
                void'(samples_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("tb_apu_nonlinear_mixer_filter NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // called and returning at a falling edge; predicts at the accepting edge
    task automatic send_levels(input logic [3:0] pa, input logic [3:0] pb,
        input logic [3:0] tr, input logic [3:0] nz, input logic [6:0] dl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, dl, nz, tr, pb, pa};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        samples_due.push_back(mix_and_filter(pa, pb, tr, nz, dl));
        @(negedge clk);
    endtask

    task automatic send_random_levels();
        send_levels(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    7'($urandom_range(0, 127)));
    endtask

    // sender holds off until every sample is back, then lets the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (samples_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_coeff(input logic [anmf_pkg::CFG_IDX_W-1:0] idx,
        input logic [anmf_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == anmf_pkg::REG_HIGHPASS)
            hp_coeff = val;
        else if (idx == anmf_pkg::REG_LOWPASS)
            lp_coeff = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    // reset coefficients, silence, full scale, each channel on its own and some mixed levels
    task automatic test_directed_levels();
        calm = 1'b1;
        send_levels(0, 0, 0, 0, 0);
        send_levels(15, 15, 15, 15, 127);
        send_levels(15, 15, 15, 15, 127);
        send_levels(0, 0, 0, 0, 0);
        calm = 1'b0;
        send_levels(15, 0, 0, 0, 0);
        send_levels(0, 15, 0, 0, 0);
        send_levels(1, 0, 0, 0, 0);
        send_levels(0, 0, 15, 0, 0);
        send_levels(0, 0, 0, 15, 0);
        send_levels(0, 0, 0, 0, 127);
        send_levels(0, 0, 0, 0, 1);
        send_levels(0, 0, 1, 0, 0);
        send_levels(15, 15, 0, 0, 0);
        send_levels(0, 0, 15, 15, 127);
        send_levels(5, 10, 10, 5, 85);
        send_levels(10, 5, 5, 10, 42);
        drain();
    endtask

    // coefficient extremes, including writes to indexes that do not exist
    task automatic test_coeff_extremes();
        write_coeff(anmf_pkg::REG_HIGHPASS, 16'hFFFF);
        write_coeff(anmf_pkg::REG_LOWPASS, 16'hFFFF);
        write_coeff(anmf_pkg::REG_LOWPASS + 8'd1, 16'h0000);
        write_coeff(8'hFF, 16'h1234);
        send_levels(15, 15, 15, 15, 127);
        send_levels(0, 0, 0, 0, 0);
        send_levels(15, 15, 15, 15, 127);
        drain();
        write_coeff(anmf_pkg::REG_HIGHPASS, 16'h0000);
        write_coeff(anmf_pkg::REG_LOWPASS, 16'h0000);
        send_levels(15, 15, 15, 15, 127);
        send_levels(7, 8, 9, 3, 100);
        drain();
    endtask

    // random levels under a given coefficient pair, with a calm stretch in the middle
    task automatic test_random_mix(input logic [anmf_pkg::CFG_W-1:0] hc,
        input logic [anmf_pkg::CFG_W-1:0] lc);
        write_coeff(anmf_pkg::REG_HIGHPASS, hc);
        write_coeff(anmf_pkg::REG_LOWPASS, lc);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            calm = (i >= RAND_ITEMS / 2 && i < RAND_ITEMS / 2 + 15);
            send_random_levels();
        end
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b1;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        stall_left = 0;
        hp_coeff   = anmf_pkg::HP_COEFF_RESET;
        lp_coeff   = anmf_pkg::LP_COEFF_RESET;
        hp_mem_in  = 0;
        hp_mem_out = 0;
        lp_mem_out = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_levels();
        test_coeff_extremes();
        test_random_mix(anmf_pkg::HP_COEFF_RESET, anmf_pkg::LP_COEFF_RESET);
        test_random_mix(16'hFFFF, 16'h0001);
        test_random_mix(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        test_random_mix(16'h8000, 16'hFFFF);

        if (mismatches == 0 && samples_due.size() == 0)
            $display("tb_apu_nonlinear_mixer_filter OK");
        else
            $display("tb_apu_nonlinear_mixer_filter NOT OK");
        $finish;
    end

endmodule
